### rtl/cfi_nor_flash_command_engine_top_defines.svh
// Assertion macros for the NOR flash command engine.
`ifndef CFI_NOR_FLASH_COMMAND_ENGINE_TOP_DEFINES_SVH
`define CFI_NOR_FLASH_COMMAND_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define CFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CFE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CFE_ASSERT(lbl, prop, msg)
`define CFE_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### rtl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// Types and constants shared by the NOR flash command engine.
// ----------------------------------------------------------------------------
`default_nettype none
package cfe_pkg;
  localparam int unsigned FlashBytes = 65536;
  localparam int unsigned EraseBlockBytes = 4096;
  localparam int unsigned BufferBytes = 256;
  localparam int unsigned AddrW = $clog2(FlashBytes);
  localparam int unsigned BlkW = $clog2(EraseBlockBytes);
  localparam int unsigned BufW = $clog2(BufferBytes);
  localparam int unsigned SizeW = 17;

  localparam logic [7:0] CmdReadArray = 8'hFF;
  localparam logic [7:0] CmdReadStatus = 8'h70;
  localparam logic [7:0] CmdClearStatus = 8'h50;
  localparam logic [7:0] CmdReadId = 8'h90;
  localparam logic [7:0] CmdProgram = 8'h40;
  localparam logic [7:0] CmdErase = 8'h20;
  localparam logic [7:0] CmdBufWrite = 8'hE8;
  localparam logic [7:0] CmdConfirm = 8'hD0;
  localparam logic [7:0] StReady = 8'h80;
  localparam logic [7:0] StPerr = 8'h10;
  localparam logic [7:0] ErasedByte = 8'hFF;
endpackage
`default_nettype wire

### rtl/cfi_nor_flash_command_engine_top.sv
// ----------------------------------------------------------------------------
// cfi_nor_flash_command_engine_top
// Intel-style parallel NOR flash command engine on stream channels.
// ----------------------------------------------------------------------------
// One bus access per input item, one result item per access. The flash array
// is a RAM with one write port and one registered read port, touched one byte
// a cycle. After reset a clearing pass writes 0xFF to every array byte, one
// byte a cycle, so no item is taken until the pass is done. Erase confirm
// walks the 4 KB block one byte a cycle, stopping early at the array end.
// Buffer confirm copies buffer to array byte by byte, reading each byte from
// the buffer and then writing it to the array. The result register parts the
// two sides: the next item may be taken while a result waits for
// m_axis_tready, and the engine holds in its last step until the slot frees.
// tuser in: req_type; tdata in: offset[15:0], access_bytes[18:16],
// write_data[50:19]. tdata out: read_data; tuser out: error.
`default_nettype none
`include "cfi_nor_flash_command_engine_top_defines.svh"
module cfi_nor_flash_command_engine_top
  import cfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // offset[15:0], access_bytes[18:16], write_data[50:19], zeros[55:51]
  input  wire logic [55:0] s_axis_tdata,
  // req_type
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[31:0]
  output logic [31:0]      m_axis_tdata,
  // error
  output logic             m_axis_tuser
);
  typedef enum logic [2:0] {
    MArray, MStatus, MDevid, MProg, MErase, MCount, MData, MConfirm
  } mode_e;
  typedef enum logic [2:0] {
    SClear, SIdle, SRead, SWrite, SErase, SCopyRd, SCopyWr, SDone
  } fsm_e;

  logic [7:0] mem_q [FlashBytes];
  logic [7:0] buf_q [BufferBytes];

  fsm_e st_q, st_d;
  mode_e mode_q, mode_d;
  logic [7:0] status_q, status_d;
  logic [AddrW-1:0] erase_addr_q, erase_addr_d, buf_base_q, buf_base_d;
  logic [7:0] left_q, left_d;
  logic [8:0] fill_q, fill_d;
  logic [SizeW-1:0] size_q, size_d;

  logic [AddrW-1:0] off_q, off_d;
  logic [2:0] nb_q, nb_d;
  logic [31:0] val_q, val_d;
  logic [2:0] idx_q, idx_d;
  logic [BlkW:0] cnt_q, cnt_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [31:0] rd_q, rd_d;
  logic err_q, err_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic out_err_q, out_err_d;

  // memory ports
  logic mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd, mem_rd_q;
  logic buf_we;
  logic [BufW-1:0] buf_wa, buf_ra;
  logic [7:0] buf_wd, buf_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[mem_ra];
  end
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_q[buf_wa] <= buf_wd;
    buf_rd_q <= buf_q[buf_ra];
  end

  logic [SizeW-1:0] eff;
  assign eff = (size_q > SizeW'(FlashBytes)) ? SizeW'(FlashBytes) : size_q;

  logic [7:0] cmd;
  logic [SizeW-1:0] end_q_sum, buf_end;
  assign cmd = val_q[7:0];
  assign end_q_sum = SizeW'(off_q) + SizeW'(nb_q);
  assign buf_end = SizeW'(buf_base_q) + SizeW'(fill_q);
  logic [AddrW-1:0] blk_base;
  assign blk_base = {erase_addr_q[AddrW-1:BlkW], BlkW'(0)};
  logic [SizeW-1:0] ers_addr;
  assign ers_addr = SizeW'(blk_base) + SizeW'(cnt_q);

  assign cfg_ready_o = (st_q == SIdle);
  assign s_axis_tready = (st_q == SIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_err_q;

  always_comb begin
    st_d = st_q; mode_d = mode_q; status_d = status_q;
    erase_addr_d = erase_addr_q; buf_base_d = buf_base_q;
    left_d = left_q; fill_d = fill_q; size_d = size_q;
    off_d = off_q; nb_d = nb_q; val_d = val_q; idx_d = idx_q; cnt_d = cnt_q;
    clr_d = clr_q; rd_d = rd_q; err_d = err_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q; out_err_d = out_err_q;
    mem_we = 1'b0;
    mem_wa = off_q + AddrW'(idx_q);
    mem_ra = off_q + AddrW'(idx_q);
    mem_wd = val_q[8*idx_q +: 8];
    buf_we = 1'b0;
    buf_wa = fill_q[BufW-1:0];
    buf_wd = val_q[8*idx_q +: 8];
    buf_ra = cnt_q[BufW-1:0];
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (cfg_valid_i && cfg_ready_o) size_d = cfg_data_i;
    case (st_q)
      SClear: begin
        mem_we = 1'b1; mem_wa = clr_q; mem_wd = ErasedByte;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == '1) st_d = SIdle;
      end
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          off_d = s_axis_tdata[15:0];
          nb_d = s_axis_tdata[18:16];
          val_d = s_axis_tdata[50:19];
          idx_d = '0; cnt_d = '0; rd_d = '0; err_d = 1'b1;
          if (s_axis_tdata[18:16] != 3'd0 && s_axis_tdata[18:16] <= 3'd4 &&
              SizeW'(s_axis_tdata[15:0]) < eff) begin
            st_d = s_axis_tuser ? SWrite : SRead;
          end else st_d = SDone;
        end
      end
      SRead: begin
        if (mode_q == MArray) begin
          if (end_q_sum > eff) st_d = SDone;
          else begin
            err_d = 1'b0;
            idx_d = idx_q + 3'd1; cnt_d = cnt_q + (BlkW+1)'(1);
            if (cnt_q != '0) rd_d[8*(idx_q-3'd1) +: 8] = mem_rd_q;
            if (cnt_q == (BlkW+1)'(nb_q)) st_d = SDone;
          end
        end else begin
          err_d = 1'b0; st_d = SDone;
          for (int i = 0; i < 4; i++)
            if (3'(i) < nb_q) rd_d[8*i +: 8] = (mode_q == MDevid) ? 8'h00 : status_q;
        end
      end
      SWrite: begin
        err_d = 1'b0; st_d = SDone;
        case (mode_q)
          MArray, MStatus, MDevid: begin
            case (cmd)
              CmdReadArray: mode_d = MArray;
              CmdReadStatus: mode_d = MStatus;
              CmdClearStatus: begin status_d = StReady; mode_d = MArray; end
              CmdReadId: mode_d = MDevid;
              CmdProgram: mode_d = MProg;
              CmdErase: begin mode_d = MErase; erase_addr_d = off_q; end
              CmdBufWrite: begin mode_d = MCount; buf_base_d = off_q; end
              default: err_d = 1'b1;
            endcase
          end
          MProg: begin
            if (end_q_sum > eff) begin
              status_d = status_q | StPerr; mode_d = MArray; err_d = 1'b1;
            end else begin
              mem_we = 1'b1;
              if (idx_q + 3'd1 < nb_q) begin
                idx_d = idx_q + 3'd1; st_d = SWrite;
              end else mode_d = MArray;
            end
          end
          MErase: begin
            if (cmd != CmdConfirm || off_q != erase_addr_q) begin
              status_d = status_q | StPerr; mode_d = MArray; err_d = 1'b1;
            end else begin
              st_d = SErase; mode_d = MArray;
            end
          end
          MCount: begin
            if (cmd == 8'd0) begin mode_d = MArray; err_d = 1'b1; end
            else begin left_d = cmd; fill_d = '0; mode_d = MData; end
          end
          MData: begin
            if (idx_q == '0 && SizeW'(off_q) != buf_end) begin
              mode_d = MArray; err_d = 1'b1;
            end else if (left_q != 8'd0 && idx_q < nb_q) begin
              buf_we = !fill_q[8];
              fill_d = fill_q + 9'd1; left_d = left_q - 8'd1;
              idx_d = idx_q + 3'd1; st_d = SWrite;
            end else if (left_q == 8'd0) mode_d = MConfirm;
          end
          MConfirm: begin
            if (cmd != CmdConfirm || SizeW'(buf_base_q) >= eff || buf_end > eff) begin
              status_d = status_q | StPerr; mode_d = MArray; err_d = 1'b1;
            end else begin
              mode_d = MArray; st_d = SCopyRd;
            end
          end
          default: begin mode_d = MArray; err_d = 1'b1; end
        endcase
      end
      SErase: begin
        mem_we = 1'b1; mem_wa = ers_addr[AddrW-1:0]; mem_wd = ErasedByte;
        if (cnt_q == (BlkW+1)'(EraseBlockBytes - 1) || ers_addr + SizeW'(1) >= eff)
          st_d = SDone;
        cnt_d = cnt_q + (BlkW+1)'(1);
      end
      SCopyRd: begin
        if ((BlkW+1)'(fill_q) == cnt_q || cnt_q == (BlkW+1)'(BufferBytes)) st_d = SDone;
        else begin cnt_d = cnt_q + (BlkW+1)'(1); st_d = SCopyWr; end
      end
      SCopyWr: begin
        mem_we = 1'b1; mem_wa = buf_base_q + AddrW'(cnt_q) - AddrW'(1);
        mem_wd = buf_rd_q;
        st_d = SCopyRd;
      end
      SDone: begin
        // hold here while the previous result still waits
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1; out_data_d = err_q ? 32'd0 : rd_q;
          out_err_d = err_q; st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; mode_q <= MArray; status_q <= StReady;
      erase_addr_q <= '0; buf_base_q <= '0; left_q <= '0; fill_q <= '0;
      size_q <= SizeW'(FlashBytes);
      off_q <= '0; nb_q <= '0; val_q <= '0; idx_q <= '0; cnt_q <= '0;
      clr_q <= '0; rd_q <= '0; err_q <= 1'b0;
      out_valid_q <= 1'b0; out_data_q <= '0; out_err_q <= 1'b0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; status_q <= status_d;
      erase_addr_q <= erase_addr_d; buf_base_q <= buf_base_d;
      left_q <= left_d; fill_q <= fill_d; size_q <= size_d;
      off_q <= off_d; nb_q <= nb_d; val_q <= val_d; idx_q <= idx_d; cnt_q <= cnt_d;
      clr_q <= clr_d; rd_q <= rd_d; err_q <= err_d;
      out_valid_q <= out_valid_d; out_data_q <= out_data_d; out_err_q <= out_err_d;
    end
  end

  `CFE_ASSERT(a_no_accept_busy, s_axis_tready |-> (st_q == SIdle), "accept while busy")
  `CFE_ASSERT(a_err_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0), "error data")
  `CFE_ASSERT(a_fill_cap, (st_q == SIdle) |-> (fill_q <= 9'd256), "fill overflow")
  `CFE_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result dropped")
endmodule
`default_nettype wire

### dv/tb_cfi_nor_flash_command_engine_top.sv
// ----------------------------------------------------------------------------
// tb_cfi_nor_flash_command_engine_top
// Drives bus accesses into the NOR flash command engine. A behavioral flash
// model in this file predicts each result, unless a directed row gives it,
// and each result is checked field by field. The run starts with a directed
// table, then moves on to random command sequences under several array
// sizes, with random backpressure on both streams outside the calm phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_cfi_nor_flash_command_engine_top
  import cfe_pkg::*;
();

  typedef enum logic [2:0] {
    MdArray, MdStatus, MdId, MdProg, MdErase, MdCount, MdData, MdConfirm
  } flash_mode_e;

  typedef struct {
    logic [31:0] rd;
    bit          err;
  } access_result_t;

  typedef struct {
    bit          wr;
    logic [15:0] off;
    logic [2:0]  nb;
    logic [31:0] d;
    bit          typed;
    logic [31:0] exp_rd;
    bit          exp_err;
  } dir_row_t;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  cfi_nor_flash_command_engine_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // flash model state
  logic [7:0]  flash_mem [0:FlashBytes-1];
  logic [7:0]  buf_mem [0:BufferBytes-1];
  flash_mode_e md;
  logic [7:0]  status_q;
  int unsigned erase_addr, buf_base, buf_left, buf_fill, array_size_q;

  access_result_t pending_results[$];
  dir_row_t       dir_rows[$];
  int unsigned    fail_count;
  int unsigned    sent_items;
  int unsigned    cycle_count;
  bit             calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // result checker and result-side backpressure
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.rd) report_mismatch("read_data", m_axis_tdata, want.rd);
        if (m_axis_tuser !== want.err)
          report_mismatch("error", 32'(m_axis_tuser), 32'(want.err));
      end
    end
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  function automatic int unsigned eff_bytes();
    return array_size_q < FlashBytes ? array_size_q : FlashBytes;
  endfunction

  function automatic bit fits(input int unsigned start, input int unsigned len);
    if (start >= eff_bytes()) return 1'b0;
    return (eff_bytes() - start) >= len;
  endfunction

  function automatic void abort_sequence(input bit perr);
    if (perr) status_q = status_q | StPerr;
    md = MdArray;
  endfunction

  function automatic void flash_reset();
    for (int i = 0; i < FlashBytes; i++) flash_mem[i] = ErasedByte;
    md = MdArray;
    status_q = StReady;
    erase_addr = 0;
    buf_base = 0;
    buf_left = 0;
    buf_fill = 0;
    array_size_q = 65536;
  endfunction

  function automatic access_result_t predict_access(input bit wr, input logic [15:0] off,
                                                    input logic [2:0] nb,
                                                    input logic [31:0] d);
    access_result_t r;
    int unsigned o, n, start;
    logic [7:0] cmd, fill_byte;
    r.rd = '0;
    r.err = 1'b1;
    o = off;
    n = nb;
    cmd = d[7:0];
    if (n == 0 || n > 4 || o >= eff_bytes()) return r;
    if (!wr) begin
      if (md == MdArray) begin
        if (!fits(o, n)) return r;
        for (int i = 0; i < n; i++) r.rd |= 32'(flash_mem[o+i]) << (8*i);
      end else begin
        fill_byte = (md == MdId) ? 8'h00 : status_q;
        for (int i = 0; i < n; i++) r.rd |= 32'(fill_byte) << (8*i);
      end
      r.err = 1'b0;
      return r;
    end
    case (md)
      MdArray, MdStatus, MdId: begin
        case (cmd)
          CmdReadArray:   md = MdArray;
          CmdReadStatus:  md = MdStatus;
          CmdClearStatus: begin
            status_q = StReady;
            md = MdArray;
          end
          CmdReadId:      md = MdId;
          CmdProgram:     md = MdProg;
          CmdErase: begin
            md = MdErase;
            erase_addr = o;
          end
          CmdBufWrite: begin
            md = MdCount;
            buf_base = o;
          end
          default: return r;
        endcase
      end
      MdProg: begin
        if (!fits(o, n)) begin
          abort_sequence(1'b1);
          return r;
        end
        for (int i = 0; i < n; i++) flash_mem[o+i] = d[8*i +: 8];
        md = MdArray;
      end
      MdErase: begin
        if (cmd != CmdConfirm || o != erase_addr) begin
          abort_sequence(1'b1);
          return r;
        end
        start = (erase_addr / EraseBlockBytes) * EraseBlockBytes;
        for (int i = 0; i < EraseBlockBytes && start + i < eff_bytes(); i++)
          flash_mem[start+i] = ErasedByte;
        md = MdArray;
      end
      MdCount: begin
        if (cmd == 0) begin
          abort_sequence(1'b0);
          return r;
        end
        buf_left = cmd;
        buf_fill = 0;
        md = MdData;
      end
      MdData: begin
        if (o != buf_base + buf_fill) begin
          abort_sequence(1'b0);
          return r;
        end
        // bytes beyond the remaining count are dropped
        for (int i = 0; i < n && buf_left > 0; i++) begin
          if (buf_fill < BufferBytes) buf_mem[buf_fill] = d[8*i +: 8];
          buf_fill = (buf_fill + 1) & 'h1FF;
          buf_left--;
        end
        if (buf_left == 0) md = MdConfirm;
      end
      default: begin
        if (cmd != CmdConfirm || !fits(buf_base, buf_fill)) begin
          abort_sequence(1'b1);
          return r;
        end
        for (int i = 0; i < buf_fill && i < BufferBytes; i++)
          flash_mem[buf_base+i] = buf_mem[i];
        md = MdArray;
      end
    endcase
    r.err = 1'b0;
    return r;
  endfunction

  task automatic send_access(input bit wr, input logic [15:0] off, input logic [2:0] nb,
                             input logic [31:0] d, input bit typed = 1'b0,
                             input logic [31:0] exp_rd = '0, input bit exp_err = 1'b0);
    access_result_t r;
    while (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, d, nb, off};
    s_axis_tuser <= wr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_access(wr, off, nb, d);
    if (typed) begin
      r.rd = exp_rd;
      r.err = exp_err;
    end
    pending_results.push_back(r);
    sent_items++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_array_size(input logic [16:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    array_size_q = value;
  endtask

  function automatic void add_row(input bit wr, input logic [15:0] off, input logic [2:0] nb,
                                  input logic [31:0] d, input bit typed = 1'b0,
                                  input logic [31:0] exp_rd = '0,
                                  input bit exp_err = 1'b0);
    dir_row_t row;
    row = '{wr, off, nb, d, typed, exp_rd, exp_err};
    dir_rows.push_back(row);
  endfunction

  // mostly a hot window near the base so reads see earlier writes
  function automatic logic [15:0] pick_offset();
    int unsigned sel, hot;
    sel = $urandom_range(99);
    hot = eff_bytes() < 512 ? eff_bytes() : 512;
    if (sel < 70) return 16'($urandom_range(hot - 1));
    if (sel < 92) return 16'($urandom_range(eff_bytes() - 1));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [2:0] pick_width();
    return ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
  endfunction

  task automatic random_phase(input int unsigned n_items);
    int unsigned stop_at, kind, cnt, pos;
    logic [15:0] base;
    logic [2:0] nb;
    logic [7:0] junk_cmd;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      kind = $urandom_range(99);
      base = pick_offset();
      if (kind < 30) begin
        send_access(1'b0, base, pick_width(), $urandom);
      end else if (kind < 45) begin
        send_access(1'b1, base, 3'd1, {24'($urandom), CmdProgram});
        send_access(1'b1, pick_offset(), pick_width(), $urandom);
      end else if (kind < 49) begin
        send_access(1'b1, base, 3'd1, {24'($urandom), CmdErase});
        if ($urandom_range(3) == 0)
          send_access(1'b1, pick_offset(), 3'd1, $urandom);
        else
          send_access(1'b1, base, pick_width(), {24'($urandom), CmdConfirm});
      end else if (kind < 72) begin
        send_access(1'b1, base, 3'd1, {24'($urandom), CmdBufWrite});
        if ($urandom_range(19) == 0) cnt = 0;
        else if ($urandom_range(19) == 0) cnt = $urandom_range(255);
        else cnt = $urandom_range(1, 24);
        send_access(1'b1, base, 3'd1, {24'($urandom), 8'(cnt)});
        pos = 0;
        while (pos < cnt) begin
          nb = 3'($urandom_range(1, 4));
          if ($urandom_range(49) == 0)
            send_access(1'b1, 16'(base + pos + 1), nb, $urandom);
          else
            send_access(1'b1, 16'(base + pos), nb, $urandom);
          pos += nb;
        end
        if ($urandom_range(9) == 0)
          send_access(1'b1, base, 3'd1, $urandom);
        else
          send_access(1'b1, base, pick_width(), {24'($urandom), CmdConfirm});
      end else if (kind < 90) begin
        case ($urandom_range(3))
          0: junk_cmd = CmdReadStatus;
          1: junk_cmd = CmdReadId;
          2: junk_cmd = CmdClearStatus;
          default: junk_cmd = CmdReadArray;
        endcase
        send_access(1'b1, base, pick_width(), {24'($urandom), junk_cmd});
      end else begin
        send_access(1'b1, base, pick_width(), $urandom);
      end
    end
  endtask

  initial begin
    dir_row_t row;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    fail_count = 0;
    sent_items = 0;
    cycle_count = 0;
    calm = 1'b0;
    flash_reset();

    // erased after reset, range ends, bad widths, status and ID reads, unknown command
    add_row(1'b0, 16'h0000, 3'd4, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(1'b0, 16'hFFFC, 3'd4, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(1'b0, 16'hFFFD, 3'd4, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(1'b0, 16'h0000, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(1'b0, 16'h0000, 3'd5, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(1'b1, 16'h0000, 3'd7, 32'hFFFF_FF70, 1'b1, 32'h0, 1'b1);
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdReadStatus}, 1'b1, 32'h0, 1'b0);
    add_row(1'b0, 16'h000A, 3'd2, 32'h0, 1'b1, 32'h0000_8080, 1'b0);
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdReadId}, 1'b1, 32'h0, 1'b0);
    add_row(1'b0, 16'h0003, 3'd3, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(1'b1, 16'h0000, 3'd1, 32'h12, 1'b1, 32'h0, 1'b1);
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdReadArray}, 1'b1, 32'h0, 1'b0);
    // known command leaving the mode unchanged is fine
    add_row(1'b1, 16'h0000, 3'd4, {24'hFFFFFF, CmdReadArray}, 1'b1, 32'h0, 1'b0);
    add_row(1'b1, 16'h0010, 3'd1, {24'h0, CmdProgram});
    add_row(1'b1, 16'h0010, 3'd4, 32'hA5C3_1E77);
    add_row(1'b0, 16'h000F, 3'd4, 32'h0);
    // program past the end, then status shows the error bit
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdProgram});
    add_row(1'b1, 16'hFFFE, 3'd4, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdReadStatus});
    add_row(1'b0, 16'h0000, 3'd4, 32'h0, 1'b1, 32'h9090_9090, 1'b0);
    add_row(1'b1, 16'h0000, 3'd1, {24'h0, CmdClearStatus});
    add_row(1'b1, 16'h1234, 3'd1, {24'h0, CmdErase});
    add_row(1'b1, 16'h1234, 3'd1, {24'h0, CmdConfirm});
    // erase confirm at another offset
    add_row(1'b1, 16'h2000, 3'd1, {24'h0, CmdErase});
    add_row(1'b1, 16'h2001, 3'd1, {24'h0, CmdConfirm}, 1'b1, 32'h0, 1'b1);
    add_row(1'b1, 16'h0020, 3'd1, {24'h0, CmdBufWrite});
    add_row(1'b1, 16'h0020, 3'd1, 32'h0, 1'b1, 32'h0, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_access(row.wr, row.off, row.nb, row.d, row.typed, row.exp_rd, row.exp_err);
    end

    random_phase(200);
    write_array_size(17'h1FFFF);
    random_phase(150);
    calm = 1'b1;
    write_array_size(17'd1);
    random_phase(60);
    write_array_size(17'd300);
    random_phase(140);
    calm = 1'b0;
    write_array_size(17'd4097);
    random_phase(150);
    write_array_size(17'd65536);
    random_phase(200);

    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/cfe_pkg.sv
rtl/cfi_nor_flash_command_engine_top.sv
dv/tb_cfi_nor_flash_command_engine_top.sv
